// ===== sv/rsmp_pkg.sv =====
// Shared constants, codes and types for the linear interpolation resampler.
// Used by every module of the block; depends on nothing.
package rsmp_pkg;

	// Fixed by the widths of the payload and register fields
	localparam int MAX_LANES   = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;

	// Read position: two integer bits over the fraction
	localparam int POS_W    = FRAC_BITS + 2;
	localparam int STEP_W   = FRAC_BITS + 2;
	localparam int FRAMES_W = 16;
	localparam int CHAN_W   = 4;

	// Lane product: difference (one bit wider than a sample) times fraction
	localparam int PROD_W = SAMPLE_BITS + 1 + FRAC_BITS;

	localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRAC_BITS;
	localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(1) << (FRAC_BITS - 1);
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(2) << FRAC_BITS;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = STEP_W;

	localparam logic [CFG_IDX_W-1:0] REG_STEP       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_FRAMES = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = CFG_IDX_W'(2);

	localparam logic [STEP_W-1:0]   STEP_RESET     = STEP_W'(1) << FRAC_BITS;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET   = '0;
	localparam logic [CHAN_W-1:0]   CHANNELS_RESET = CHAN_W'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OUT,
		ST_MUL
	} state_t;

	// Controls from the sequencer to the lanes and the output register
	typedef struct packed {
		logic                 sel_port;
		logic                 cap_en;
		logic                 mul_en;
		logic                 prev_ld;
		logic                 out_ld;
		logic                 run_end;
		logic                 buffer_done;
		logic [MAX_LANES-1:0] active;
		logic [FRAC_BITS-1:0] frac;
	} ctrl_t;

endpackage

// ===== sv/rsmp_lane.sv =====
// One interpolation lane: holds the previous and current sample of its lane
// and forms prev + ((cur - prev) * frac >>> FRAC_BITS). Depends on rsmp_pkg.
module rsmp_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rsmp_pkg::ctrl_t                      ctl,
	input  logic                                 active,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] result
);

	logic signed [rsmp_pkg::SAMPLE_BITS-1:0] prev_q;
	logic signed [rsmp_pkg::SAMPLE_BITS-1:0] cur_q;
	logic signed [rsmp_pkg::SAMPLE_BITS-1:0] cur;
	logic signed [rsmp_pkg::SAMPLE_BITS:0]   diff;
	logic signed [rsmp_pkg::PROD_W-1:0]      diff_ext;
	logic signed [rsmp_pkg::PROD_W-1:0]      frac_ext;
	logic signed [rsmp_pkg::PROD_W-1:0]      prod_s1;

	// Take the sample straight from the input beat, later from the held copy
	assign cur = ctl.sel_port ? sample : cur_q;

	// Difference and product operands
	assign diff     = (rsmp_pkg::SAMPLE_BITS + 1)'(cur) - (rsmp_pkg::SAMPLE_BITS + 1)'(prev_q);
	assign diff_ext = rsmp_pkg::PROD_W'(diff);
	assign frac_ext = $signed(rsmp_pkg::PROD_W'(ctl.frac));

	// Hold the current frame sample for the rest of the item
	always_ff @(posedge clk) begin
		if (ctl.cap_en) begin
			cur_q <= sample;
		end
	end

	// Register the product
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= diff_ext * frac_ext;
		end
	end

	// Advance the previous sample at the end of an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctl.prev_ld) begin
			prev_q <= cur;
		end
	end

	// Floor shift and add; only the low sample bits of the sum are kept
	always_comb begin
		if (active) begin
			result = prev_q + prod_s1[rsmp_pkg::FRAC_BITS +: rsmp_pkg::SAMPLE_BITS];
		end else begin
			result = '0;
		end
	end

endmodule

// ===== sv/rsmp_ctrl.sv =====
// Sequencer of the resampler: configuration registers, read position,
// output count and the per-item state machine. Depends on rsmp_pkg.
module rsmp_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rsmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               first,
	input  logic                               out_free,
	output rsmp_pkg::ctrl_t                    ctl
);

	rsmp_pkg::state_t state_q, state_d;

	logic [rsmp_pkg::STEP_W-1:0]   step_q;
	logic [rsmp_pkg::FRAMES_W-1:0] out_frames_q;
	logic [rsmp_pkg::CHAN_W-1:0]   channels_q;
	logic [rsmp_pkg::POS_W-1:0]    pos_q;
	logic [rsmp_pkg::FRAMES_W-1:0] cnt_q;
	logic                          second_q;

	logic [rsmp_pkg::STEP_W-1:0]   step_eff;
	logic [rsmp_pkg::POS_W-1:0]    pos_n;
	logic [rsmp_pkg::FRAMES_W-1:0] cnt_n;
	logic                          accept;
	logic                          can_emit;
	logic                          last;
	logic                          emit_done;

	function automatic logic [rsmp_pkg::POS_W-1:0] pos_wrap(input logic [rsmp_pkg::POS_W-1:0] p);
		return (p >= rsmp_pkg::ONE_POS) ? p - rsmp_pkg::ONE_POS : p;
	endfunction

	// Saturate the step into its legal range
	always_comb begin
		if (step_q < rsmp_pkg::STEP_MIN) begin
			step_eff = rsmp_pkg::STEP_MIN;
		end else if (step_q > rsmp_pkg::STEP_MAX) begin
			step_eff = rsmp_pkg::STEP_MAX;
		end else begin
			step_eff = step_q;
		end
	end

	// Position and count after the frame now being emitted
	assign pos_n    = pos_q + rsmp_pkg::POS_W'(step_eff);
	assign cnt_n    = cnt_q + rsmp_pkg::FRAMES_W'(1);
	assign can_emit = (pos_q < rsmp_pkg::ONE_POS) && (cnt_q < out_frames_q);
	assign last     = second_q || !((pos_n < rsmp_pkg::ONE_POS) && (cnt_n < out_frames_q));

	assign in_ready  = (state_q == rsmp_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign emit_done = (state_q == rsmp_pkg::ST_OUT) && out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsmp_pkg::ST_IDLE: begin
				if (accept && !first && can_emit) begin
					state_d = rsmp_pkg::ST_OUT;
				end
			end
			rsmp_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = last ? rsmp_pkg::ST_IDLE : rsmp_pkg::ST_MUL;
				end
			end
			rsmp_pkg::ST_MUL: begin
				state_d = rsmp_pkg::ST_OUT;
			end
			default: begin
				state_d = rsmp_pkg::ST_IDLE;
			end
		endcase
	end

	// Lane and output register controls
	always_comb begin
		ctl.sel_port    = (state_q == rsmp_pkg::ST_IDLE);
		ctl.cap_en      = accept;
		ctl.mul_en      = (accept && !first && can_emit) || (state_q == rsmp_pkg::ST_MUL);
		ctl.prev_ld     = (accept && (first || !can_emit)) || (emit_done && last);
		ctl.out_ld      = emit_done;
		ctl.run_end     = last;
		ctl.buffer_done = (cnt_n == out_frames_q);
		ctl.frac        = pos_q[rsmp_pkg::FRAC_BITS-1:0];
		for (int i = 0; i < rsmp_pkg::MAX_LANES; i++) begin
			ctl.active[i] = (int'(channels_q) > i);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= rsmp_pkg::STEP_RESET;
			out_frames_q <= rsmp_pkg::FRAMES_RESET;
			channels_q   <= rsmp_pkg::CHANNELS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rsmp_pkg::REG_STEP:       step_q       <= cfg_data[rsmp_pkg::STEP_W-1:0];
				rsmp_pkg::REG_OUT_FRAMES: out_frames_q <= cfg_data[rsmp_pkg::FRAMES_W-1:0];
				rsmp_pkg::REG_CHANNELS:   channels_q   <= cfg_data[rsmp_pkg::CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// State, read position and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rsmp_pkg::ST_IDLE;
			pos_q    <= '0;
			cnt_q    <= '0;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				second_q <= 1'b0;
				if (first) begin
					pos_q <= '0;
					cnt_q <= '0;
				end else if (!can_emit) begin
					pos_q <= pos_wrap(pos_q);
				end
			end
			if (emit_done) begin
				cnt_q    <= cnt_n;
				second_q <= 1'b1;
				pos_q    <= last ? pos_wrap(pos_n) : pos_n;
			end
		end
	end

endmodule

// ===== sv/rsmp_merge.sv =====
// Output register: gathers the lane results and flags into one output beat
// and holds it until taken. Depends on rsmp_pkg.
module rsmp_merge (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rsmp_pkg::ctrl_t                         ctl,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] lane_res [rsmp_pkg::MAX_LANES],
	output logic                                    out_free,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_data [rsmp_pkg::MAX_LANES],
	output logic                                    run_end,
	output logic                                    buffer_done
);

	logic valid_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;

	// Load a new beat when the sequencer emits
	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			out_data    <= lane_res;
			run_end     <= ctl.run_end;
			buffer_done <= ctl.buffer_done;
		end
	end

	// Valid rises on load, drops when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.out_ld) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/linear_interp_resampler_top.sv =====
// Top level of the linear interpolation resampler: sequencer, eight lanes
// and the output register. Depends on rsmp_pkg, rsmp_ctrl, rsmp_lane, rsmp_merge.
//
//   channel   signals                         beat carries
//   cfg       cfg_valid / cfg_ready           cfg_index, cfg_data
//   in        in_valid / in_ready             first, sample_0 .. sample_7
//   out       out_valid / out_ready           out_0 .. out_7, run_end, buffer_done
//
// A frame that emits nothing is handled in the idle state alone. For each output
// frame the lane multiplier register is loaded (on acceptance for the first, in
// the multiply state for the rest) and feeds the add stage in the output state.
// Reset clears the position, count, previous frame and registers to their
// defaults. A stalled output holds the sequencer; the input is taken only
// while no frame is in work.
module linear_interp_resampler_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rsmp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rsmp_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    first,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_0,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_1,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_2,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_3,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_4,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_5,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_6,
	input  logic signed [rsmp_pkg::SAMPLE_BITS-1:0] sample_7,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_0,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_1,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_2,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_3,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_4,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_5,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_6,
	output logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_7,
	output logic                                    run_end,
	output logic                                    buffer_done
);

	rsmp_pkg::ctrl_t ctl;
	logic            out_free;

	logic signed [rsmp_pkg::SAMPLE_BITS-1:0] samples  [rsmp_pkg::MAX_LANES];
	logic signed [rsmp_pkg::SAMPLE_BITS-1:0] lane_res [rsmp_pkg::MAX_LANES];
	logic signed [rsmp_pkg::SAMPLE_BITS-1:0] out_data [rsmp_pkg::MAX_LANES];

	// Gather the input lanes
	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;
	assign samples[4] = sample_4;
	assign samples[5] = sample_5;
	assign samples[6] = sample_6;
	assign samples[7] = sample_7;

	// Spread the output lanes
	assign out_0 = out_data[0];
	assign out_1 = out_data[1];
	assign out_2 = out_data[2];
	assign out_3 = out_data[3];
	assign out_4 = out_data[4];
	assign out_5 = out_data[5];
	assign out_6 = out_data[6];
	assign out_7 = out_data[7];

	rsmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.first     (first),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	for (genvar g = 0; g < rsmp_pkg::MAX_LANES; g++) begin : g_lane
		rsmp_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.active (ctl.active[g]),
			.sample (samples[g]),
			.result (lane_res[g])
		);
	end

	rsmp_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.lane_res    (lane_res),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.run_end     (run_end),
		.buffer_done (buffer_done)
	);

endmodule
